>>> hw/rtl/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types, tags and helpers for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int unsigned MIN_FILE_BYTES = 44;
  localparam logic [32:0] FIRST_CHUNK    = 33'd12;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_BAD_MAGIC = 2'd2,
    ST_PARSE_ERR = 2'd3
  } parse_status_t;

  // one file byte waiting in the input register
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    parse_status_t status;
    logic [15:0]   channels;
    logic [31:0]   rate;
    logic [15:0]   bits;
    logic [31:0]   offset;
    logic [31:0]   length;
  } wavhp_result_t;

  // byte k of a four-character tag, first character first
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0: b = tag[31:24];
      2'd1: b = tag[23:16];
      2'd2: b = tag[15:8];
      2'd3: b = tag[7:0];
      default: b = tag[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/wavhp_in_stage.sv
// ----------------------------------------------------------------------------
// wavhp_in_stage
// Input register for file bytes; holds a byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wavhp_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  logic [7:0]            file_byte,
  input  logic                  final_byte,
  input  logic                  consume,
  output wavhp_pkg::byte_item_t item
);
  import wavhp_pkg::*;

  logic accept;

  assign byte_stall = item.valid && !consume;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (accept) begin
      item.valid <= 1'b1;
    end else if (consume) begin
      item.valid <= 1'b0;
    end
    if (accept) begin
      item.data <= file_byte;
      item.last <= final_byte;
    end
  end

endmodule

>>> hw/rtl/wavhp_parse_core.sv
// ----------------------------------------------------------------------------
// wavhp_parse_core
// Per-byte parser state: magic check, chunk walk, fmt capture, final result.
// ----------------------------------------------------------------------------
module wavhp_parse_core #(
  parameter int POS_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic                     last,
  input  logic [7:0]               data,
  output wavhp_pkg::wavhp_result_t result
);
  import wavhp_pkg::*;

  localparam logic [POS_BITS-1:0] POS_LIMIT = '1;
  localparam logic [POS_BITS-1:0] POS_MIN   = POS_BITS'(MIN_FILE_BYTES);

  // state
  logic [POS_BITS-1:0] byte_position, byte_position_next;
  logic [32:0]         next_chunk_start, next_chunk_start_next;
  logic [55:0]         header_window, header_window_next;
  logic                magic_ok, magic_ok_next;
  logic [POS_BITS-1:0] fmt_start, fmt_start_next;
  logic                fmt_active, fmt_active_next;
  logic [15:0]         staged_ch, staged_ch_next;
  logic [31:0]         staged_rate, staged_rate_next;
  logic [15:0]         staged_bits, staged_bits_next;
  logic [15:0]         commit_ch, commit_ch_next;
  logic [31:0]         commit_rate, commit_rate_next;
  logic [15:0]         commit_bits, commit_bits_next;
  logic                data_found, data_found_next;
  logic [POS_BITS-1:0] data_start, data_start_next;
  logic [31:0]         data_size, data_size_next;

  logic                active;
  logic [POS_BITS-1:0] idx;
  logic [POS_BITS-1:0] fsize;
  logic [POS_BITS-1:0] fmt_off;
  logic                fmt_hit;
  logic [33:0]         hdr_diff;
  logic                in_hdr;
  logic                hdr_done;
  logic [63:0]         window_new;
  logic [31:0]         chunk_id;
  logic [31:0]         chunk_size;
  logic                data_now;
  logic [POS_BITS-1:0] left;
  logic [31:0]         clamp_len;
  parse_status_t       status;

  assign idx    = byte_position;
  assign active = fire && (idx != POS_LIMIT);
  assign fsize  = active ? idx + 1'b1 : idx;

  assign fmt_off    = idx - fmt_start;
  assign fmt_hit    = fmt_active && (idx >= fmt_start) && (fmt_off[POS_BITS-1:5] == '0);
  assign hdr_diff   = 34'(idx) - {1'b0, next_chunk_start};
  assign in_hdr     = !data_found && !hdr_diff[33] && (hdr_diff[32:3] == '0);
  assign hdr_done   = in_hdr && (hdr_diff[2:0] == 3'd7);
  assign window_new = {header_window, data};
  assign chunk_id   = window_new[63:32];
  assign chunk_size = {window_new[7:0], window_new[15:8], window_new[23:16], window_new[31:24]};
  assign data_now   = hdr_done && (chunk_id == TAG_DATA);

  always_comb begin
    byte_position_next    = byte_position;
    next_chunk_start_next = next_chunk_start;
    header_window_next    = header_window;
    magic_ok_next         = magic_ok;
    fmt_start_next        = fmt_start;
    fmt_active_next       = fmt_active;
    staged_ch_next        = staged_ch;
    staged_rate_next      = staged_rate;
    staged_bits_next      = staged_bits;
    commit_ch_next        = commit_ch;
    commit_rate_next      = commit_rate;
    commit_bits_next      = commit_bits;
    data_found_next       = data_found;
    data_start_next       = data_start;
    data_size_next        = data_size;

    if (active) begin
      byte_position_next = idx + 1'b1;

      if (idx < POS_BITS'(4) && data != tag_byte(TAG_RIFF, idx[1:0])) begin
        magic_ok_next = 1'b0;
      end
      if (idx >= POS_BITS'(8) && idx < POS_BITS'(12) &&
          data != tag_byte(TAG_WAVE, idx[1:0])) begin
        magic_ok_next = 1'b0;
      end

      if (fmt_hit) begin
        unique case (fmt_off[4:0])
          5'd10:   staged_ch_next[7:0]     = data;
          5'd11:   staged_ch_next[15:8]    = data;
          5'd12:   staged_rate_next[7:0]   = data;
          5'd13:   staged_rate_next[15:8]  = data;
          5'd14:   staged_rate_next[23:16] = data;
          5'd15:   staged_rate_next[31:24] = data;
          5'd22:   staged_bits_next[7:0]   = data;
          5'd23:   staged_bits_next[15:8]  = data;
          default: ;
        endcase
        if (fmt_off[4:0] == 5'd23) begin
          commit_ch_next   = staged_ch_next;
          commit_rate_next = staged_rate_next;
          commit_bits_next = staged_bits_next;
          fmt_active_next  = 1'b0;
        end
      end

      if (in_hdr) begin
        header_window_next = window_new[55:0];
      end
      if (hdr_done) begin
        if (chunk_id == TAG_FMT) begin
          // a newer fmt header restarts any open capture
          fmt_start_next   = next_chunk_start[POS_BITS-1:0];
          fmt_active_next  = 1'b1;
          staged_ch_next   = '0;
          staged_rate_next = '0;
          staged_bits_next = '0;
        end
        if (data_now) begin
          data_found_next = 1'b1;
          data_start_next = idx + 1'b1;
          data_size_next  = chunk_size;
        end else begin
          next_chunk_start_next = next_chunk_start + 33'd8 + {1'b0, chunk_size};
        end
      end
    end
  end

  // clamp the declared size to what the file still holds
  assign left = fsize - data_start;
  always_comb begin
    clamp_len = '0;
    if (!data_now && data_start < fsize) begin
      clamp_len = (data_size < 32'(left)) ? data_size : 32'(left);
    end
  end

  always_comb begin
    priority if (fsize < POS_MIN) begin
      status = ST_SHORT;
    end else if (!magic_ok_next) begin
      status = ST_BAD_MAGIC;
    end else if (!data_found_next || commit_ch_next == '0 || commit_rate_next == '0 ||
                 commit_bits_next == '0) begin
      status = ST_PARSE_ERR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    result        = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.channels = commit_ch_next;
      result.rate     = commit_rate_next;
      result.bits     = commit_bits_next;
      result.offset   = 32'(data_start_next);
      result.length   = clamp_len;
    end
  end

  // the last byte of a file returns the parser to its reset state
  always_ff @(posedge clk) begin
    if (rst || (fire && last)) begin
      byte_position    <= '0;
      next_chunk_start <= FIRST_CHUNK;
      header_window    <= '0;
      magic_ok         <= 1'b1;
      fmt_start        <= '0;
      fmt_active       <= 1'b0;
      staged_ch        <= '0;
      staged_rate      <= '0;
      staged_bits      <= '0;
      commit_ch        <= '0;
      commit_rate      <= '0;
      commit_bits      <= '0;
      data_found       <= 1'b0;
      data_start       <= '0;
      data_size        <= '0;
    end else begin
      byte_position    <= byte_position_next;
      next_chunk_start <= next_chunk_start_next;
      header_window    <= header_window_next;
      magic_ok         <= magic_ok_next;
      fmt_start        <= fmt_start_next;
      fmt_active       <= fmt_active_next;
      staged_ch        <= staged_ch_next;
      staged_rate      <= staged_rate_next;
      staged_bits      <= staged_bits_next;
      commit_ch        <= commit_ch_next;
      commit_rate      <= commit_rate_next;
      commit_bits      <= commit_bits_next;
      data_found       <= data_found_next;
      data_start       <= data_start_next;
      data_size        <= data_size_next;
    end
  end

endmodule

>>> hw/rtl/wavhp_out_stage.sv
// ----------------------------------------------------------------------------
// wavhp_out_stage
// Result register; holds a result while the receiver stalls.
// ----------------------------------------------------------------------------
module wavhp_out_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  wavhp_pkg::wavhp_result_t result_in,
  input  logic                     result_stall,
  output logic                     result_valid,
  output wavhp_pkg::wavhp_result_t result_out,
  output logic                     room
);
  import wavhp_pkg::*;

  assign room = !(result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

>>> hw/rtl/wav_header_parser_top.sv
// ----------------------------------------------------------------------------
// wav_header_parser_top
// RIFF/WAVE header parser: one file byte in, one result per file out.
// ----------------------------------------------------------------------------
// Feed the file one byte per item on file_byte, with final_byte set on the
// last byte. The block checks the RIFF and WAVE tags, walks the chunk headers
// from offset 12, captures the fmt fields and stops at the data chunk.
// The last byte produces one result item carrying parse_status, the format
// fields and the data offset and clamped length; other bytes produce none.
// Throughput: one byte per cycle unless a waiting last byte stalls the byte
// channel; set by the single parser state update. The result is valid once
// the last byte has passed the input register, then the result register.
// After the last byte the parser returns to its reset state, so the next
// file may follow in the next cycle.
// Reset (rst, synchronous) empties both registers and clears the parser.
// When the receiver stalls, the result holds; bytes keep flowing until a
// last byte reaches the input register, which then waits for the result to
// be taken and stalls the byte channel meanwhile.
// ----------------------------------------------------------------------------
module wav_header_parser_top #(
  parameter int POS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  file_byte,
  input  logic        final_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  parse_status,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate_hz,
  output logic [15:0] sample_bits,
  output logic [31:0] data_offset,
  output logic [31:0] data_length
);
  import wavhp_pkg::*;

  byte_item_t    item;
  wavhp_result_t core_result;
  wavhp_result_t held_result;
  logic          room;
  logic          consume;

  // a non-final byte never waits on the result register
  assign consume = item.valid && (!item.last || room);

  wavhp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .file_byte  (file_byte),
    .final_byte (final_byte),
    .consume    (consume),
    .item       (item)
  );

  wavhp_parse_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (consume),
    .last   (item.last),
    .data   (item.data),
    .result (core_result)
  );

  wavhp_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (consume && item.last),
    .result_in    (core_result),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_out   (held_result),
    .room         (room)
  );

  assign parse_status   = held_result.status;
  assign channel_count  = held_result.channels;
  assign sample_rate_hz = held_result.rate;
  assign sample_bits    = held_result.bits;
  assign data_offset    = held_result.offset;
  assign data_length    = held_result.length;

endmodule

>>> hw/rtl/wavhp_checker.sv
// ----------------------------------------------------------------------------
// wavhp_checker
// Port-level checks for the WAV header parser, bound to the top level.
// ----------------------------------------------------------------------------
module wavhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic        final_byte,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  parse_status,
  input logic [15:0] channel_count,
  input logic [31:0] sample_rate_hz,
  input logic [15:0] sample_bits,
  input logic [31:0] data_offset,
  input logic [31:0] data_length
);
  import wavhp_pkg::*;

  // hold a stalled result
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(parse_status) && $stable(channel_count) &&
      $stable(sample_rate_hz) && $stable(sample_bits) && $stable(data_offset) &&
      $stable(data_length))
    else $error("result payload changed while stalled");

  // a failed parse reports no format or data fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && parse_status != ST_OK |-> channel_count == '0 &&
      sample_rate_hz == '0 && sample_bits == '0 && data_offset == '0 && data_length == '0)
    else $error("non-ok result carries fields");

  a_ok_format: assert property (@(posedge clk) disable iff (rst)
    result_valid && parse_status == ST_OK |-> channel_count != '0 &&
      sample_rate_hz != '0 && sample_bits != '0)
    else $error("ok result with empty format");

  // a fresh result follows an accepted last byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(byte_valid && !byte_stall && final_byte, 2))
    else $error("result without a last byte");

endmodule

bind wav_header_parser_top wavhp_checker u_wavhp_checker (.*);

>>> bench/wav_header_parser_top_tb.sv
// ----------------------------------------------------------------------------
// wav_header_parser_top_tb
// Streams WAV files byte by byte through the header parser and checks every
// per-file result against an in-bench parser model. Directed files cover the
// tag, size, fmt and data corner cases. Random files follow, mostly well
// formed with random content, over several idle and stall mixes, a long
// receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module wav_header_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wavhp_pkg::*;

  localparam int          CYCLE_LIMIT     = 200_000;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          FILES_PER_PHASE = 1;
  localparam logic [63:0] POS_LIMIT       = (64'd1 << 32) - 64'd1;
  localparam logic [63:0] CHUNK_MASK      = (64'd1 << 33) - 64'd1;
  localparam logic [31:0] TAG_LIST        = 32'h4C49_5354;

  // Parser model plus the queue of per-file results it predicts.
  class wav_result_board;
    bit [63:0] pos, chunk_at, window, fmt_at, staged, committed, data_at, data_size;
    bit magic_good, fmt_open, data_seen;
    wavhp_result_t expected_results[$];
    int errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      pos = 0;
      chunk_at = 64'(FIRST_CHUNK);
      window = 0;
      magic_good = 1'b1;
      fmt_at = 0;
      fmt_open = 1'b0;
      staged = 0;
      committed = 0;
      data_seen = 1'b0;
      data_at = 0;
      data_size = 0;
    endfunction

    function bit [7:0] tag_char(bit [31:0] tag, bit [1:0] k);
      return tag[8*(3-k) +: 8];
    endfunction

    function void parse_byte(bit [63:0] idx, bit [7:0] b);
      bit [63:0] off;
      bit [31:0] id, lo, size;
      if (idx < 4 && b != tag_char(TAG_RIFF, idx[1:0])) magic_good = 1'b0;
      if (idx >= 8 && idx < 12 && b != tag_char(TAG_WAVE, idx[1:0])) magic_good = 1'b0;

      if (fmt_open && idx >= fmt_at) begin
        off = idx - fmt_at;
        if (off >= 10 && off <= 15) staged[8*(off-10) +: 8] = b;
        else if (off == 22 || off == 23) staged[48 + 8*(off-22) +: 8] = b;
        if (off == 23) begin
          committed = staged;
          fmt_open = 1'b0;
        end
      end

      if (!data_seen && idx >= chunk_at && idx - chunk_at < 8) begin
        window = {window[55:0], b};
        if (idx - chunk_at == 7) begin
          id = window[63:32];
          lo = window[31:0];
          size = {lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
          if (id == TAG_FMT) begin
            fmt_at = chunk_at;
            fmt_open = 1'b1;
            staged = 0;
          end else if (id == TAG_DATA) begin
            data_seen = 1'b1;
            data_at = chunk_at + 8;
            data_size = size;
          end
          if (!data_seen) chunk_at = (chunk_at + 8 + size) & CHUNK_MASK;
        end
      end
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      wavhp_result_t r;
      bit [63:0] len;
      if (pos < POS_LIMIT) begin
        parse_byte(pos, b);
        pos = pos + 1;
      end
      if (!last) return;
      r = '0;
      if (pos < MIN_FILE_BYTES) r.status = ST_SHORT;
      else if (!magic_good) r.status = ST_BAD_MAGIC;
      else if (!data_seen || committed[15:0] == 0 || committed[47:16] == 0 ||
               committed[63:48] == 0) r.status = ST_PARSE_ERR;
      else begin
        len = 0;
        if (data_at < pos) begin
          len = pos - data_at;
          if (data_size < len) len = data_size;
        end
        r.status   = ST_OK;
        r.channels = committed[15:0];
        r.rate     = committed[47:16];
        r.bits     = committed[63:48];
        r.offset   = data_at[31:0];
        r.length   = len[31:0];
      end
      expected_results.push_back(r);
      clear_parse();
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s expected 0x%0h got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(wavhp_result_t got);
      wavhp_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no file pending, parse_status %0d", got.status);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      cmp_field("parse_status", 32'(want.status), 32'(got.status));
      cmp_field("channel_count", 32'(want.channels), 32'(got.channels));
      cmp_field("sample_rate_hz", want.rate, got.rate);
      cmp_field("sample_bits", 32'(want.bits), 32'(got.bits));
      cmp_field("data_offset", want.offset, got.offset);
      cmp_field("data_length", want.length, got.length);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  file_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  parse_status;
  logic [15:0] channel_count;
  logic [31:0] sample_rate_hz;
  logic [15:0] sample_bits;
  logic [31:0] data_offset;
  logic [31:0] data_length;

  wav_result_board board = new();
  logic [7:0]      file_q[$];
  int              send_idle_pct = 0;
  int              rx_stall_pct = 0;
  bit              hold_armed = 1'b0;
  logic            hold_on = 1'b0;
  int              cycle_count = 0;

  wav_header_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .file_byte     (file_byte),
    .final_byte    (final_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .parse_status  (parse_status),
    .channel_count (channel_count),
    .sample_rate_hz(sample_rate_hz),
    .sample_bits   (sample_bits),
    .data_offset   (data_offset),
    .data_length   (data_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // monitors: sample pre-edge values of both channels
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) board.note_byte(file_byte, final_byte);
  end

  always @(posedge clk) begin
    wavhp_result_t got;
    if (!rst && result_valid && !result_stall) begin
      got.status   = parse_status_t'(parse_status);
      got.channels = channel_count;
      got.rate     = sample_rate_hz;
      got.bits     = sample_bits;
      got.offset   = data_offset;
      got.length   = data_length;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (hold_on) result_stall <= 1'b1;
    else result_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // long receiver hold-off, counted here once armed
  initial begin
    wait (hold_armed);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  function void put_tag(logic [31:0] tag);
    for (int k = 3; k >= 0; k--) file_q.push_back(tag[8*k +: 8]);
  endfunction

  function void put_le32(logic [31:0] v);
    for (int k = 0; k < 4; k++) file_q.push_back(v[8*k +: 8]);
  endfunction

  function void put_riff(logic [31:0] riff_size);
    put_tag(TAG_RIFF);
    put_le32(riff_size);
    put_tag(TAG_WAVE);
  endfunction

  function void put_chunk(logic [31:0] tag, logic [31:0] declared, int n);
    put_tag(tag);
    put_le32(declared);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  // fmt chunk; a size under 16 cuts the body, extra size adds random bytes
  function void put_fmt(logic [15:0] ch, logic [31:0] rate, logic [15:0] bits, int size);
    logic [7:0] body[16];
    body = '{8'h01, 8'h00, ch[7:0], ch[15:8], rate[7:0], rate[15:8], rate[23:16],
             rate[31:24], 8'h10, 8'hB1, 8'h02, 8'h00, 8'h04, 8'h00, bits[7:0], bits[15:8]};
    put_tag(TAG_FMT);
    put_le32(size);
    for (int k = 0; k < size; k++) file_q.push_back(k < 16 ? body[k] : 8'($urandom));
  endfunction

  function logic [31:0] pick_val();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    file_byte  <= b;
    final_byte <= last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic send_file();
    for (int k = 0; k < file_q.size(); k++) send_byte(file_q[k], k == file_q.size() - 1);
    file_q.delete();
  endtask

  // hold the byte channel idle until every pending result is out
  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic make_random_file();
    int kind, n, cut;
    logic [31:0] declared;
    logic [31:0] junk_tag;
    kind = $urandom_range(99);
    if (kind < 15) begin
      n = $urandom_range(1, 70);
      if (kind < 5) put_riff($urandom);
      repeat (n) file_q.push_back(8'($urandom));
    end else begin
      put_riff($urandom);
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(2))
          0: junk_tag = TAG_LIST;
          1: junk_tag = TAG_FMT;
          default: junk_tag = $urandom;
        endcase
        n = $urandom_range(0, 12);
        put_chunk(junk_tag, n, n);
      end
      if ($urandom_range(9) != 0)
        put_fmt(16'(pick_val()), pick_val(), 16'(pick_val()),
                $urandom_range(3) == 0 ? $urandom_range(0, 24) : 16 + 2 * $urandom_range(1));
      n = $urandom_range(0, 16);
      case ($urandom_range(3))
        0: declared = $urandom;
        1: declared = $urandom_range(0, 20);
        default: declared = n;
      endcase
      put_chunk($urandom_range(9) != 0 ? TAG_DATA : TAG_LIST, declared, n);
      if ($urandom_range(9) == 0) file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
      end
    end
  endtask

  task automatic run_random_phase(input int sp, input int rp);
    send_idle_pct = sp;
    rx_stall_pct <= rp;
    repeat (FILES_PER_PHASE) begin
      make_random_file();
      send_file();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // plain file, exact data size
    put_riff(32'd52); put_fmt(16'd2, 32'd44100, 16'd16, 16); put_chunk(TAG_DATA, 8, 8);
    send_file();
    // data size larger than the file: clamp
    put_riff(32'd0); put_fmt(16'd1, 32'd8000, 16'd8, 16); put_chunk(TAG_DATA, 100, 4);
    send_file();
    // exactly 44 bytes, huge declared size, no PCM bytes
    put_riff(32'hFFFF_FFFF); put_fmt(16'd1, 32'd22050, 16'd8, 16);
    put_chunk(TAG_DATA, 32'hFFFF_FFFF, 0);
    send_file();
    // one byte short of the minimum
    put_riff(32'd36); put_fmt(16'd1, 32'd22050, 16'd8, 16); put_chunk(TAG_DATA, 0, 0);
    void'(file_q.pop_back());
    send_file();
    // single-byte files
    file_q.push_back(8'hFF); send_file();
    file_q.push_back(8'h00); send_file();
    // bad RIFF tag, bad WAVE tag
    put_riff(32'd44); put_fmt(16'd2, 32'd48000, 16'd24, 16); put_chunk(TAG_DATA, 0, 0);
    file_q[0] = 8'h00;
    send_file();
    put_riff(32'd44); put_fmt(16'd2, 32'd48000, 16'd24, 16); put_chunk(TAG_DATA, 0, 0);
    file_q[11] = file_q[11] ^ 8'h01;
    send_file();
    // bad magic on a short file still reports short
    put_tag(32'h0); repeat (10) file_q.push_back(8'h5A);
    send_file();
    // no data chunk
    put_riff(32'd60); put_fmt(16'd2, 32'd44100, 16'd16, 16); put_chunk(TAG_LIST, 0, 0);
    send_file();
    // no fmt chunk
    put_riff(32'd60); put_chunk(TAG_DATA, 24, 24);
    send_file();
    // zero channels, zero rate, zero bits
    put_riff(0); put_fmt(16'd0, 32'd44100, 16'd16, 16); put_chunk(TAG_DATA, 0, 0); send_file();
    put_riff(0); put_fmt(16'd2, 32'd0, 16'd16, 16); put_chunk(TAG_DATA, 0, 0); send_file();
    put_riff(0); put_fmt(16'd2, 32'd44100, 16'd0, 16); put_chunk(TAG_DATA, 0, 0); send_file();
    // field extremes behind a skipped chunk
    put_riff(32'hFFFF_FFFF); put_chunk(TAG_LIST, 6, 6);
    put_fmt(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 18); put_chunk(TAG_DATA, 4, 4);
    send_file();
    // empty fmt chunk overlapped by a second fmt header: restart capture
    put_riff(0); put_fmt(16'd3, 32'd1000, 16'd12, 0); put_fmt(16'd4, 32'd96000, 16'd32, 16);
    put_chunk(TAG_DATA, 6, 6);
    send_file();
    // short fmt chunk: capture completes inside the data chunk
    put_riff(0); put_fmt(16'd5, 32'd11025, 16'd20, 4); put_chunk(TAG_DATA, 40, 12);
    send_file();
    // fmt chunk cut off by the end of the file
    put_riff(0); put_chunk(TAG_LIST, 12, 12); put_fmt(16'd2, 32'd44100, 16'd16, 6);
    send_file();
    // all ones, all zeros
    repeat (44) file_q.push_back(8'hFF); send_file();
    repeat (44) file_q.push_back(8'h00); send_file();
    wait_drained();

    run_random_phase(0, 0);
    run_random_phase(54, 0);
    run_random_phase(0, 54);
    run_random_phase(9, 9);

    // receiver holds off while files keep coming
    send_idle_pct = 0;
    rx_stall_pct <= 0;
    hold_armed = 1'b1;
    repeat (2) begin
      make_random_file();
      send_file();
    end
    wait_drained();

    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/wavhp_pkg.sv
hw/rtl/wavhp_in_stage.sv
hw/rtl/wavhp_parse_core.sv
hw/rtl/wavhp_out_stage.sv
hw/rtl/wav_header_parser_top.sv
hw/rtl/wavhp_checker.sv
bench/wav_header_parser_top_tb.sv
